### rtl/integer_to_english_word_codes_top_macros.svh
// assertion macros for the integer to english word codes block
// used by the checker module; needs clk and rst_n in the using scope
`ifndef INTEGER_TO_ENGLISH_WORD_CODES_TOP_MACROS_SVH
`define INTEGER_TO_ENGLISH_WORD_CODES_TOP_MACROS_SVH

// clocked property, disabled during reset
`define I2W_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2w assertion failed");

// condition that must never hold
`define I2W_ASSERT_NEVER(label, cond) \
    `I2W_ASSERT(label, !(cond))

`endif

### rtl/i2w_pkg.sv
// shared types and constants for the integer to english word codes block
// no dependencies
package i2w_pkg;

    localparam int NUMBER_W  = 31;
    localparam int WORD_W    = 5;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W     = 4 * BCD_DIGITS;
    localparam int PAD_W     = 48;
    localparam int GROUPS    = 4;
    localparam int CNT_W     = $clog2(NUMBER_W);

    localparam logic [WORD_W-1:0] WORD_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEN       = 5'd10;
    localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] WORD_THOUSAND  = 5'd29;

    localparam logic [2:0] SLOT_DIGIT   = 3'd0;
    localparam logic [2:0] SLOT_HUNDRED = 3'd1;
    localparam logic [2:0] SLOT_REST    = 3'd2;
    localparam logic [2:0] SLOT_ONES    = 3'd3;
    localparam logic [2:0] SLOT_SCALE   = 3'd4;

    typedef enum logic [1:0] {
        CONV_IDLE  = 2'b01,
        CONV_SHIFT = 2'b10
    } conv_state_t;

    typedef enum logic [1:0] {
        SPELL_IDLE = 2'b01,
        SPELL_RUN  = 2'b10
    } spell_state_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [BCD_W-1:0] bcd;
    } conv_out_t;

endpackage

### rtl/i2w_number_if.sv
// input channel carrying one number per transfer
// depends on i2w_pkg
interface i2w_number_if;
    logic                        valid;
    logic                        ready;
    logic [i2w_pkg::NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

### rtl/i2w_word_if.sv
// output channel carrying one word code per transfer
// depends on i2w_pkg
interface i2w_word_if;
    logic                       valid;
    logic                       ready;
    logic [i2w_pkg::WORD_W-1:0] word;
    logic                       last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink (input valid, input word, input last_word, output ready);
endinterface

### rtl/i2w_bcd_conv.sv
// bit-serial binary to bcd converter, one shift-and-adjust step per cycle
// depends on i2w_pkg
module i2w_bcd_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [i2w_pkg::NUMBER_W-1:0] number,
    output i2w_pkg::conv_out_t           status
);

    localparam logic [i2w_pkg::CNT_W-1:0] CNT_LAST = i2w_pkg::CNT_W'(i2w_pkg::NUMBER_W - 1);

    i2w_pkg::conv_state_t             state_reg, state_next;
    logic [i2w_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic [i2w_pkg::NUMBER_W-1:0]     bin_reg, bin_next;
    logic [i2w_pkg::BCD_W-1:0]        bcd_reg, bcd_next;
    logic [i2w_pkg::BCD_W-1:0]        adj;

    always_comb
    begin
        for (int k = 0; k < i2w_pkg::BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        unique case (state_reg)
            i2w_pkg::CONV_IDLE:
            begin
                if (start)
                begin
                    bin_next   = number;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = i2w_pkg::CONV_SHIFT;
                end
            end
            i2w_pkg::CONV_SHIFT:
            begin
                bcd_next = {adj[i2w_pkg::BCD_W-2:0], bin_reg[i2w_pkg::NUMBER_W-1]};
                bin_next = {bin_reg[i2w_pkg::NUMBER_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = i2w_pkg::CONV_IDLE;
                end
            end
            default:
            begin
                state_next = i2w_pkg::CONV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2w_pkg::CONV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = (state_reg != i2w_pkg::CONV_IDLE) || done_reg;
    assign status.done = done_reg;
    assign status.bcd  = bcd_reg;

endmodule

### rtl/i2w_speller.sv
// word sequencer: walks three-digit groups and word slots, emitting words
// depends on i2w_pkg and i2w_word_if
module i2w_speller (
    input  logic               clk,
    input  logic               rst_n,
    input  i2w_pkg::conv_out_t conv,
    output logic               busy,
    i2w_word_if.source         word_chan
);

    i2w_pkg::spell_state_t          state_reg, state_next;
    logic [i2w_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic [1:0]                     level_reg, level_next;
    logic [2:0]                     slot_reg, slot_next;
    logic                           ovalid_reg, ovalid_next;
    logic [i2w_pkg::WORD_W-1:0]     oword_reg, oword_next;
    logic                           olast_reg, olast_next;

    logic [i2w_pkg::PAD_W-1:0]      pad;
    logic [11:0]                    grp;
    logic [3:0]                     hund, tens, ones;
    logic [i2w_pkg::GROUPS-1:0]     grp_nz;
    logic [4:0]                     slot_v;
    logic [i2w_pkg::WORD_W-1:0]     slot_word;
    logic                           later, lower, is_last, can_load;

    always_comb
    begin
        pad  = {{(i2w_pkg::PAD_W - i2w_pkg::BCD_W){1'b0}}, bcd_reg};
        for (int g = 0; g < i2w_pkg::GROUPS; g++)
            grp_nz[g] = (pad[12*g +: 12] != 12'd0);
        grp  = pad[12*level_reg +: 12];
        hund = grp[11:8];
        tens = grp[7:4];
        ones = grp[3:0];

        slot_v[i2w_pkg::SLOT_DIGIT]   = (hund != 4'd0);
        slot_v[i2w_pkg::SLOT_HUNDRED] = (hund != 4'd0);
        slot_v[i2w_pkg::SLOT_REST]    = (tens != 4'd0) || (ones != 4'd0);
        slot_v[i2w_pkg::SLOT_ONES]    = (tens >= 4'd2) && (ones != 4'd0);
        slot_v[i2w_pkg::SLOT_SCALE]   = (level_reg != 2'd0);

        case (slot_reg)
            i2w_pkg::SLOT_DIGIT:   slot_word = {1'b0, hund};
            i2w_pkg::SLOT_HUNDRED: slot_word = i2w_pkg::WORD_HUNDRED;
            i2w_pkg::SLOT_REST:
            begin
                if (tens >= 4'd2)
                    slot_word = i2w_pkg::WORD_TENS_BASE + {1'b0, tens};
                else if (tens == 4'd1)
                    slot_word = i2w_pkg::WORD_TEN + {1'b0, ones};
                else
                    slot_word = {1'b0, ones};
            end
            i2w_pkg::SLOT_ONES:    slot_word = {1'b0, ones};
            default:               slot_word = i2w_pkg::WORD_HUNDRED + {3'b000, level_reg};
        endcase

        later    = |(slot_v & ~((5'd2 << slot_reg) - 5'd1));
        lower    = |(grp_nz & ((4'd1 << level_reg) - 4'd1));
        is_last  = !later && !lower;
        can_load = !ovalid_reg || word_chan.ready;
    end

    always_comb
    begin
        state_next  = state_reg;
        bcd_next    = bcd_reg;
        level_next  = level_reg;
        slot_next   = slot_reg;
        oword_next  = oword_reg;
        olast_next  = olast_reg;
        ovalid_next = ovalid_reg && !word_chan.ready;
        unique case (state_reg)
            i2w_pkg::SPELL_IDLE:
            begin
                if (conv.done)
                begin
                    bcd_next   = conv.bcd;
                    level_next = 2'd3;
                    slot_next  = i2w_pkg::SLOT_DIGIT;
                    state_next = i2w_pkg::SPELL_RUN;
                end
            end
            i2w_pkg::SPELL_RUN:
            begin
                if (grp_nz == '0)
                begin
                    if (can_load)
                    begin
                        ovalid_next = 1'b1;
                        oword_next  = i2w_pkg::WORD_ZERO;
                        olast_next  = 1'b1;
                        state_next  = i2w_pkg::SPELL_IDLE;
                    end
                end
                else if (!grp_nz[level_reg])
                begin
                    level_next = level_reg - 2'd1;
                    slot_next  = i2w_pkg::SLOT_DIGIT;
                end
                else if (!slot_v[slot_reg] || can_load)
                begin
                    if (slot_v[slot_reg])
                    begin
                        ovalid_next = 1'b1;
                        oword_next  = slot_word;
                        olast_next  = is_last;
                    end
                    if (slot_v[slot_reg] && is_last)
                        state_next = i2w_pkg::SPELL_IDLE;
                    else if (slot_reg == i2w_pkg::SLOT_SCALE)
                    begin
                        level_next = level_reg - 2'd1;
                        slot_next  = i2w_pkg::SLOT_DIGIT;
                    end
                    else
                        slot_next = slot_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = i2w_pkg::SPELL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= i2w_pkg::SPELL_IDLE;
            level_reg  <= '0;
            slot_reg   <= i2w_pkg::SLOT_DIGIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            slot_reg   <= slot_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        oword_reg <= oword_next;
        olast_reg <= olast_next;
    end

    assign busy                = (state_reg != i2w_pkg::SPELL_IDLE);
    assign word_chan.valid     = ovalid_reg;
    assign word_chan.word      = oword_reg;
    assign word_chan.last_word = olast_reg;

endmodule

### rtl/integer_to_english_word_codes_top.sv
// top level of the integer to english word codes block
// depends on i2w_pkg, i2w_number_if, i2w_word_if, i2w_bcd_conv, i2w_speller
//
//  channel      role    payload
//  number_chan  sink    number[30:0]
//  word_chan    source  word[4:0], last_word
//
// one number passes the input transfer, the bit-serial bcd converter, a handoff
// into the speller, then the speller, which takes a step for each word slot and
// for each skipped zero group
// reset clears all control state; nothing else needs clearing
// a stall on word_chan holds the output register and stops the speller at its next word
// number_chan is ready again once the final word sits in the output register
module integer_to_english_word_codes_top (
    input  logic        clk,
    input  logic        rst_n,
    i2w_number_if.sink  number_chan,
    i2w_word_if.source  word_chan
);

    i2w_pkg::conv_out_t conv;
    logic               spell_busy;
    logic               start;

    assign number_chan.ready = !conv.busy && !spell_busy;
    assign start             = number_chan.valid && number_chan.ready;

    i2w_bcd_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .number (number_chan.number),
        .status (conv)
    );

    i2w_speller u_speller (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv      (conv),
        .busy      (spell_busy),
        .word_chan (word_chan)
    );

endmodule

### rtl/i2w_checker.sv
// port-level checker for the integer to english word codes block, with bind
// depends on i2w_pkg and integer_to_english_word_codes_top_macros.svh
`include "integer_to_english_word_codes_top_macros.svh"

module i2w_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [i2w_pkg::WORD_W-1:0] out_word,
    input logic                       out_last
);

    `I2W_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    `I2W_ASSERT(a_zero_alone, out_valid && (out_word == i2w_pkg::WORD_ZERO) |-> out_last)
    `I2W_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready)
    `I2W_ASSERT_NEVER(a_no_word_early, $rose(out_valid) && $past(in_valid && in_ready))

endmodule

bind integer_to_english_word_codes_top i2w_checker u_i2w_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number_chan.valid),
    .in_ready  (number_chan.ready),
    .out_valid (word_chan.valid),
    .out_ready (word_chan.ready),
    .out_word  (word_chan.word),
    .out_last  (word_chan.last_word)
);

### verif/i2w_word_checker.sv
`timescale 1ns / 100ps
// checker for the integer to english word codes block: predicts word codes per number
// watches number_chan and word_chan; depends on i2w_pkg, i2w_number_if, i2w_word_if
module i2w_word_checker
    import i2w_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    i2w_number_if  number_chan,
    i2w_word_if    word_chan,
    output int     errors,
    output int     pending,
    output int     numbers_done,
    output int     words_done,
    output int     longest_wording
);

    localparam logic [WORD_W-1:0] WORD_MILLION = 5'd30;
    localparam logic [WORD_W-1:0] WORD_BILLION = 5'd31;
    localparam int MAX_WORDS = 16;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_word;
    } word_code_t;

    word_code_t expected_words[$];
    int         mismatches;
    int         number_count;
    int         word_count;
    int         longest;

    function automatic logic [WORD_W-1:0] scale_word(input int level);
        case (level)
            3:       return WORD_BILLION;
            2:       return WORD_MILLION;
            default: return WORD_THOUSAND;
        endcase
    endfunction

    function automatic void spell_number(input logic [NUMBER_W-1:0] number);
        logic [WORD_W-1:0] words [MAX_WORDS];
        int unsigned       value;
        int unsigned       divisor;
        int unsigned       group;
        int unsigned       rest;
        int                count;
        word_code_t        code;
        value   = number;
        divisor = 1000000000;
        count   = 0;
        if (value == 0)
        begin
            words[0] = WORD_ZERO;
            count    = 1;
        end
        else
        begin
            for (int level = 3; level >= 0; level--)
            begin
                group = (value / divisor) % 1000;
                if (group != 0)
                begin
                    rest = group % 100;
                    if (group >= 100)
                    begin
                        words[count]     = WORD_W'(group / 100);
                        words[count + 1] = WORD_HUNDRED;
                        count += 2;
                    end
                    if (rest != 0 && rest < 20)
                    begin
                        words[count] = WORD_W'(rest);
                        count++;
                    end
                    else if (rest >= 20)
                    begin
                        words[count] = WORD_TENS_BASE + WORD_W'(rest / 10);
                        count++;
                        if (rest % 10 != 0)
                        begin
                            words[count] = WORD_W'(rest % 10);
                            count++;
                        end
                    end
                    if (level > 0)
                    begin
                        words[count] = scale_word(level);
                        count++;
                    end
                end
                divisor = divisor / 1000;
            end
        end
        for (int i = 0; i < count; i++)
        begin
            code.word      = words[i];
            code.last_word = (i == count - 1);
            expected_words.push_back(code);
        end
        if (count > longest)
            longest = count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_code_t wanted;
        if (!rst_n)
        begin
            expected_words.delete();
            mismatches      = 0;
            number_count    = 0;
            word_count      = 0;
            longest         = 0;
            errors          <= 0;
            pending         <= 0;
            numbers_done    <= 0;
            words_done      <= 0;
            longest_wording <= 0;
        end
        else
        begin
            if (word_chan.valid && word_chan.ready)
            begin
                word_count++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word transfer: word %0d last_word %0b",
                                 $realtime, word_chan.word, word_chan.last_word);
                end
                else
                begin
                    wanted = expected_words.pop_front();
                    if (wanted.word !== word_chan.word
                        || wanted.last_word !== word_chan.last_word)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: word mismatch: expected %0d/%0b got %0d/%0b",
                                     $realtime, wanted.word, wanted.last_word,
                                     word_chan.word, word_chan.last_word);
                    end
                end
            end
            if (number_chan.valid && number_chan.ready)
            begin
                number_count++;
                spell_number(number_chan.number);
            end
            errors          <= mismatches;
            pending         <= expected_words.size();
            numbers_done    <= number_count;
            words_done      <= word_count;
            longest_wording <= longest;
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// top of the integer to english word codes testbench: clock, reset, numbers, verdict
// depends on i2w_pkg, i2w_number_if, i2w_word_if, i2w_word_checker and the block
module tb;

    localparam int NUMBER_W = i2w_pkg::NUMBER_W;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 42;
    localparam logic [NUMBER_W-1:0] NUMBER_MAX = 31'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   sender_idle_pct;
    int   receiver_idle_pct = 52;
    int   quiet_cycles = 0;
    int   errors;
    int   pending;
    int   numbers_done;
    int   words_done;
    int   longest_wording;

    i2w_number_if number_chan ();
    i2w_word_if   word_chan ();

    integer_to_english_word_codes_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_chan (number_chan),
        .word_chan   (word_chan)
    );

    i2w_word_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .number_chan     (number_chan),
        .word_chan       (word_chan),
        .errors          (errors),
        .pending         (pending),
        .numbers_done    (numbers_done),
        .words_done      (words_done),
        .longest_wording (longest_wording)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_chan.ready <= 1'b0;
        else
            word_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((number_chan.valid && number_chan.ready) || (word_chan.valid && word_chan.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_group();
        case ($urandom_range(4))
            0:       return 0;
            1:       return $urandom_range(1, 19);
            2:       return $urandom_range(2, 9) * 10;
            3:       return $urandom_range(20, 99);
            default: return $urandom_range(100, 999);
        endcase
    endfunction

    function automatic logic [NUMBER_W-1:0] pick_number();
        longint candidate;
        case ($urandom_range(9))
            0, 1: return NUMBER_W'($urandom());
            2:    return NUMBER_W'($urandom_range(999));
            default:
            begin
                candidate = longint'($urandom_range(2)) * 1000000000
                          + longint'(pick_group()) * 1000000
                          + longint'(pick_group()) * 1000
                          + longint'(pick_group());
                if (candidate > longint'(NUMBER_MAX))
                    candidate -= 1000000000;
                return NUMBER_W'(candidate);
            end
        endcase
    endfunction

    // valid stays high across back-to-back transfers unless the sender draws idle cycles
    task automatic send_number(input logic [NUMBER_W-1:0] number);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            number_chan.valid <= 1'b0;
            @(posedge clk);
        end
        number_chan.valid  <= 1'b1;
        number_chan.number <= number;
        do
            @(posedge clk);
        while (!number_chan.ready);
    endtask

    task automatic wait_for_words();
        number_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic [NUMBER_W-1:0] directed [$];
        directed = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd21,
                     31'd99, 31'd100, 31'd101, 31'd110, 31'd999, 31'd1000, 31'd1001,
                     31'd12345, 31'd1010010, 31'd100000000, 31'd1000000,
                     31'd1000000000, 31'd1000000001, 31'd1234567891, 31'd1777777777,
                     31'd2000000000, NUMBER_MAX};
        number_chan.valid  <= 1'b0;
        number_chan.number <= '0;
        sender_idle_pct = 31;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_number(directed[i]);
        wait_for_words();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 31;
                    receiver_idle_pct <= 52;
                end
                1:
                begin
                    sender_idle_pct = 52;
                    receiver_idle_pct <= 31;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct <= 0;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_number(pick_number());
            wait_for_words();
        end

        repeat (64) @(posedge clk);
        $display("spelled %0d numbers into %0d word codes, longest wording %0d words",
                 numbers_done, words_done, longest_wording);
        $display("%0d word mismatches, %0d words still outstanding", errors, pending);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### integer_to_english_word_codes_top.f
+incdir+rtl
rtl/i2w_pkg.sv
rtl/i2w_number_if.sv
rtl/i2w_word_if.sv
rtl/i2w_bcd_conv.sv
rtl/i2w_speller.sv
rtl/integer_to_english_word_codes_top.sv
rtl/i2w_checker.sv
verif/i2w_word_checker.sv
verif/tb.sv
